// File: rtl/core/hamming_threshold_clustering_assert.svh
// Assertion macros used by the clustering datapath.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef HAMMING_THRESHOLD_CLUSTERING_ASSERT_SVH
`define HAMMING_THRESHOLD_CLUSTERING_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define HTC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("htc invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define HTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htc implication violated");

`endif

// File: rtl/core/htc_pkg.sv
`default_nettype none

package htc_pkg;

  // Fixed field widths.
  localparam int SYM_W      = 8;
  localparam int THR_W      = 10;
  localparam int IDX_W      = 6;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Distance given to sequences of different length when that is not accepted.
  localparam logic [THR_W-1:0] MISMATCH_DIST = 10'd1000;
  localparam logic [THR_W-1:0] THR_RESET     = 10'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT    = 1'b1;

  typedef enum logic [4:0] {
    ST_RECV,
    ST_FIN,
    ST_CMP_LEN,
    ST_CMP_INIT,
    ST_CMP_RD,
    ST_CMP_ACC,
    ST_CMP_END,
    ST_DECIDE,
    ST_COV_INC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_NEW_DONE,
    ST_JOIN_CHK,
    ST_JOIN_RA,
    ST_JOIN_RB,
    ST_REL_RD,
    ST_REL_WR,
    ST_JOIN_NEXT,
    ST_READ_DONE,
    ST_BEST_RD,
    ST_BEST_A,
    ST_BEST_B,
    ST_BEST_C,
    ST_BEST_NEXT,
    ST_OUT_MAP,
    ST_OUT_PAR,
    ST_OUT_BEST,
    ST_OUT_FIRST,
    ST_OUT_LOAD,
    ST_OUT_WAIT,
    ST_CLEAR
  } state_t;

  // Read address select of the component parent memory.
  typedef enum logic [1:0] {
    PAR_S,
    PAR_NEW,
    PAR_K,
    PAR_MAP
  } par_sel_t;

  // Read address select of the coverage memory.
  typedef enum logic [1:0] {
    COV_S,
    COV_FOUND,
    COV_BEST
  } cov_sel_t;

  typedef struct packed {
    logic     recv;
    logic     set_ovf;
    logic     pass_start;
    logic     cmp_init;
    logic     cmp_acc;
    logic     cmp_end;
    logic     new_start;
    logic     cov_inc;
    logic     copy_wr;
    logic     new_done;
    logic     s_inc;
    logic     join_ra;
    logic     join_rb;
    logic     rel_wr;
    logic     read_done;
    logic     best_a;
    logic     best_c;
    logic     out_load;
    logic     clear;
    par_sel_t par_sel;
    cov_sel_t cov_sel;
  } htc_cmd_t;

  typedef struct packed {
    logic in_end;
    logic eos_seen;
    logic read_full;
    logic dist_full;
    logic dcount_zero;
    logic shorter_zero;
    logic last_pos;
    logic is_equal;
    logic s_last;
    logic found;
    logic copy_last;
    logic join_done;
    logic near_s;
    logic same_root;
    logic k_last;
    logic root_is_s;
    logic rcount_zero;
    logic out_fire;
    logic out_last;
  } htc_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/hamming_threshold_clustering.sv
// Channel  Dir  Handshake      Payload
// s_axis   in   tvalid/tready  tdata symbol, tlast end of read, tuser end of set
// m_axis   out  tvalid/tready  tdata read index and label, tlast last label, tuser overflow
// cfg      in   valid/ready    register index and write data, always ready
//
// Symbols are taken one per cycle while a read streams in; tready drops at a read's end.
// That stall covers the comparison with each stored sequence; a new sequence is then
// copied into the store, older sequences are scanned for joins and each join relinks
// every parent entry, all paced by the single read port of each memory.
// After the set ends, a pass over the stored sequences builds the representatives, then
// each label is loaded and held until the output takes it, and a clear state ends the run.
// Reset is synchronous and active high; no clearing pass is needed.
`default_nettype none

module hamming_threshold_clustering
  import htc_pkg::*;
#(
  parameter int MAX_LENGTH   = 64,
  parameter int MAX_DISTINCT = 64,
  parameter int MAX_READS    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SYM_W-1:0]      s_axis_tdata,  // [7:0] symbol
  input  wire logic                  s_axis_tlast,  // end_of_read
  input  wire logic                  s_axis_tuser,  // [0] end_of_set
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [5:0] read_index, [11:6] label_read
  output logic                       m_axis_tlast,  // last
  output logic                       m_axis_tuser,  // [0] overflow
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [THR_W-1:0]      cfg_data
);

  htc_cmd_t  cmd;
  htc_stat_t stat;

  // Sequencing of compare, store, join and labeling steps.
  htc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Memories, counters and the output register.
  htc_datapath #(
    .MAX_LENGTH   (MAX_LENGTH),
    .MAX_DISTINCT (MAX_DISTINCT),
    .MAX_READS    (MAX_READS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  assign s_axis_tready = cmd.recv;

endmodule

`default_nettype wire

// File: rtl/core/htc_ctrl.sv
`default_nettype none

module htc_ctrl
  import htc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire htc_stat_t stat,
  output htc_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV:      if (stat.in_end) state_next = ST_FIN;
      ST_FIN: begin
        if (stat.read_full) state_next = ST_READ_DONE;
        else if (stat.dcount_zero) state_next = ST_DECIDE;
        else state_next = ST_CMP_LEN;
      end
      ST_CMP_LEN:   state_next = ST_CMP_INIT;
      ST_CMP_INIT:  state_next = stat.shorter_zero ? ST_CMP_END : ST_CMP_RD;
      ST_CMP_RD:    state_next = ST_CMP_ACC;
      ST_CMP_ACC:   state_next = stat.last_pos ? ST_CMP_END : ST_CMP_RD;
      ST_CMP_END:   state_next = (stat.is_equal || stat.s_last) ? ST_DECIDE : ST_CMP_LEN;
      ST_DECIDE: begin
        if (stat.found) state_next = ST_COV_INC;
        else if (stat.dist_full) state_next = ST_READ_DONE;
        else state_next = ST_COPY_RD;
      end
      ST_COV_INC:   state_next = ST_READ_DONE;
      ST_COPY_RD:   state_next = ST_COPY_WR;
      ST_COPY_WR:   state_next = stat.copy_last ? ST_NEW_DONE : ST_COPY_RD;
      ST_NEW_DONE:  state_next = ST_JOIN_CHK;
      ST_JOIN_CHK: begin
        if (stat.join_done) state_next = ST_READ_DONE;
        else if (stat.near_s) state_next = ST_JOIN_RA;
        else state_next = ST_JOIN_NEXT;
      end
      ST_JOIN_RA:   state_next = ST_JOIN_RB;
      ST_JOIN_RB:   state_next = stat.same_root ? ST_JOIN_NEXT : ST_REL_RD;
      ST_REL_RD:    state_next = ST_REL_WR;
      ST_REL_WR:    state_next = stat.k_last ? ST_JOIN_NEXT : ST_REL_RD;
      ST_JOIN_NEXT: state_next = ST_JOIN_CHK;
      ST_READ_DONE: begin
        if (!stat.eos_seen) state_next = ST_RECV;
        else if (stat.rcount_zero) state_next = ST_CLEAR;
        else state_next = ST_BEST_RD;
      end
      ST_BEST_RD:   state_next = ST_BEST_A;
      ST_BEST_A:    state_next = stat.root_is_s ? ST_BEST_NEXT : ST_BEST_B;
      ST_BEST_B:    state_next = ST_BEST_C;
      ST_BEST_C:    state_next = ST_BEST_NEXT;
      ST_BEST_NEXT: state_next = stat.s_last ? ST_OUT_MAP : ST_BEST_RD;
      ST_OUT_MAP:   state_next = ST_OUT_PAR;
      ST_OUT_PAR:   state_next = ST_OUT_BEST;
      ST_OUT_BEST:  state_next = ST_OUT_FIRST;
      ST_OUT_FIRST: state_next = ST_OUT_LOAD;
      ST_OUT_LOAD:  state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (stat.out_fire) state_next = stat.out_last ? ST_CLEAR : ST_OUT_MAP;
      end
      ST_CLEAR:     state_next = ST_RECV;
      default:      state_next = ST_RECV;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.par_sel = PAR_S;
    cmd.cov_sel = COV_S;
    unique case (state)
      ST_RECV:      cmd.recv = 1'b1;
      ST_FIN: begin
        if (stat.read_full) cmd.set_ovf = 1'b1;
        else cmd.pass_start = 1'b1;
      end
      ST_CMP_INIT:  cmd.cmp_init = 1'b1;
      ST_CMP_ACC:   cmd.cmp_acc = 1'b1;
      ST_CMP_END:   cmd.cmp_end = 1'b1;
      ST_DECIDE: begin
        if (stat.found) cmd.cov_sel = COV_FOUND;
        else if (stat.dist_full) cmd.set_ovf = 1'b1;
        else cmd.new_start = 1'b1;
      end
      ST_COV_INC:   cmd.cov_inc = 1'b1;
      ST_COPY_WR:   cmd.copy_wr = 1'b1;
      ST_NEW_DONE:  cmd.new_done = 1'b1;
      ST_JOIN_CHK:  cmd.par_sel = PAR_S;
      ST_JOIN_RA: begin
        cmd.join_ra = 1'b1;
        cmd.par_sel = PAR_NEW;
      end
      ST_JOIN_RB:   cmd.join_rb = 1'b1;
      ST_REL_RD:    cmd.par_sel = PAR_K;
      ST_REL_WR:    cmd.rel_wr = 1'b1;
      ST_JOIN_NEXT: cmd.s_inc = 1'b1;
      ST_READ_DONE: cmd.read_done = 1'b1;
      ST_BEST_A:    cmd.best_a = 1'b1;
      ST_BEST_B:    cmd.cov_sel = COV_BEST;
      ST_BEST_C:    cmd.best_c = 1'b1;
      ST_BEST_NEXT: cmd.s_inc = 1'b1;
      ST_OUT_PAR:   cmd.par_sel = PAR_MAP;
      ST_OUT_LOAD:  cmd.out_load = 1'b1;
      ST_CLEAR:     cmd.clear = 1'b1;
      default: begin
        cmd.par_sel = PAR_S;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/htc_datapath.sv
`default_nettype none

`include "hamming_threshold_clustering_assert.svh"

module htc_datapath
  import htc_pkg::*;
#(
  parameter int MAX_LENGTH   = 64,
  parameter int MAX_DISTINCT = 64,
  parameter int MAX_READS    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire htc_cmd_t              cmd,
  output htc_stat_t                  stat,
  input  wire logic                  s_axis_tvalid,
  input  wire logic [SYM_W-1:0]      s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [THR_W-1:0]      cfg_data
);

  localparam int LW   = $clog2(MAX_LENGTH + 1);
  localparam int LIW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int DW   = $clog2(MAX_DISTINCT + 1);
  localparam int SIW  = $clog2(MAX_DISTINCT);
  localparam int RW   = $clog2(MAX_READS + 1);
  localparam int RIW  = $clog2(MAX_READS);
  localparam int SD   = MAX_DISTINCT * MAX_LENGTH;
  localparam int AW   = $clog2(SD);
  localparam int BW   = $clog2(SD + 1);
  localparam int CMPW = (LW > THR_W) ? LW : THR_W;

  // Configuration registers.
  logic [THR_W-1:0] thr;
  logic             accept;

  // Control counters and flags.
  logic [LW-1:0]  cur_len;
  logic [LW-1:0]  pos;
  logic [LW-1:0]  shorter;
  logic [LW-1:0]  dsum;
  logic [DW-1:0]  dcount;
  logic [DW-1:0]  s;
  logic [DW-1:0]  k;
  logic [RW-1:0]  rcount;
  logic [RW-1:0]  r;
  logic [BW-1:0]  base;
  logic           ovf;
  logic           eos_seen;
  logic           found;
  logic           lmis;
  logic           out_valid;

  // Working registers.
  logic [SIW-1:0] fidx;
  logic [SIW-1:0] nidx;
  logic [SIW-1:0] ra;
  logic [SIW-1:0] lo;
  logic [SIW-1:0] hi;
  logic [SIW-1:0] root;
  logic [RW-1:0]  cov_s;
  logic [MAX_DISTINCT-1:0] near_vec;
  logic [IDX_W-1:0] o_idx;
  logic [IDX_W-1:0] o_label;
  logic             o_ovf;
  logic             o_last;

  // Memories and their registered read data.
  logic [SYM_W-1:0] store_mem [SD];
  logic [SYM_W-1:0] cbuf_mem  [MAX_LENGTH];
  logic [LW-1:0]    len_mem   [MAX_DISTINCT];
  logic [RW-1:0]    cov_mem   [MAX_DISTINCT];
  logic [RIW-1:0]   first_mem [MAX_DISTINCT];
  logic [SIW-1:0]   par_mem   [MAX_DISTINCT];
  logic [SIW-1:0]   best_mem  [MAX_DISTINCT];
  logic [SIW-1:0]   map_mem   [MAX_READS];
  logic [SYM_W-1:0] st_q;
  logic [SYM_W-1:0] cb_q;
  logic [LW-1:0]    len_q;
  logic [RW-1:0]    cov_q;
  logic [RIW-1:0]   first_q;
  logic [SIW-1:0]   par_q;
  logic [SIW-1:0]   best_q;
  logic [SIW-1:0]   map_q;

  // Combinational helpers.
  logic           take;
  logic           out_fire;
  logic [BW-1:0]  st_addr_full;
  logic [AW-1:0]  st_addr;
  logic [SIW-1:0] s_idx;
  logic [SIW-1:0] k_idx;
  logic [SIW-1:0] d_idx;
  logic [RIW-1:0] r_idx;
  logic [RIW-1:0] rc_idx;
  logic [SIW-1:0] par_raddr;
  logic [SIW-1:0] cov_raddr;
  logic           len_ne;
  logic [LW-1:0]  len_diff;
  logic [LW-1:0]  len_min;
  logic           near_now;

  assign take      = cmd.recv & s_axis_tvalid;
  assign out_fire  = out_valid & m_axis_tready;
  assign cfg_ready = 1'b1;

  assign st_addr_full = base + BW'(pos);
  assign st_addr      = st_addr_full[AW-1:0];
  assign s_idx        = s[SIW-1:0];
  assign k_idx        = k[SIW-1:0];
  assign d_idx        = dcount[SIW-1:0];
  assign r_idx        = r[RIW-1:0];
  assign rc_idx       = rcount[RIW-1:0];

  // Length comparison of a stored sequence against the current read.
  assign len_ne   = (len_q != cur_len);
  assign len_diff = (len_q > cur_len) ? (len_q - cur_len) : (cur_len - len_q);
  assign len_min  = (len_q < cur_len) ? len_q : cur_len;
  assign near_now = (lmis && !accept) ? (thr >= MISMATCH_DIST)
                                      : (CMPW'(dsum) <= CMPW'(thr));

  // Read address selection.
  always_comb begin
    case (cmd.par_sel)
      PAR_NEW: par_raddr = nidx;
      PAR_K:   par_raddr = k_idx;
      PAR_MAP: par_raddr = map_q;
      default: par_raddr = s_idx;
    endcase
  end

  always_comb begin
    case (cmd.cov_sel)
      COV_FOUND: cov_raddr = fidx;
      COV_BEST:  cov_raddr = best_q;
      default:   cov_raddr = s_idx;
    endcase
  end

  // Status to the controller.
  always_comb begin
    stat              = '0;
    stat.in_end       = take & (s_axis_tlast | s_axis_tuser);
    stat.eos_seen     = eos_seen;
    stat.read_full    = (rcount >= RW'(MAX_READS));
    stat.dist_full    = (dcount >= DW'(MAX_DISTINCT));
    stat.dcount_zero  = (dcount == '0);
    stat.shorter_zero = (len_min == '0);
    stat.last_pos     = ((pos + LW'(1)) == shorter);
    stat.is_equal     = !lmis && (dsum == '0);
    stat.s_last       = ((s + DW'(1)) == dcount);
    stat.found        = found;
    stat.copy_last    = ((pos + LW'(1)) == cur_len);
    stat.join_done    = (s == DW'(nidx));
    stat.near_s       = near_vec[s_idx];
    stat.same_root    = (par_q == ra);
    stat.k_last       = ((k + DW'(1)) == dcount);
    stat.root_is_s    = (par_q == s_idx);
    stat.rcount_zero  = (rcount == '0);
    stat.out_fire     = out_fire;
    stat.out_last     = ((r + RW'(1)) == rcount);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RESET;
      accept <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr    <= cfg_data;
        REG_ACCEPT:    accept <= cfg_data[0];
        default:       thr    <= thr;
      endcase
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len   <= '0;
      dcount    <= '0;
      rcount    <= '0;
      r         <= '0;
      ovf       <= 1'b0;
      eos_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        if (cur_len < LW'(MAX_LENGTH)) cur_len <= cur_len + LW'(1);
        else ovf <= 1'b1;
        if (s_axis_tlast | s_axis_tuser) eos_seen <= s_axis_tuser;
      end
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.cov_inc) rcount <= rcount + RW'(1);
      if (cmd.new_done) begin
        dcount <= dcount + DW'(1);
        rcount <= rcount + RW'(1);
      end
      if (cmd.read_done) begin
        cur_len  <= '0;
        eos_seen <= 1'b0;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      if (out_fire) begin
        out_valid <= 1'b0;
        r         <= r + RW'(1);
      end
      if (cmd.clear) begin
        cur_len <= '0;
        dcount  <= '0;
        rcount  <= '0;
        r       <= '0;
        ovf     <= 1'b0;
      end
    end
  end

  // Comparison, copy and join working registers.
  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      s     <= '0;
      base  <= '0;
      found <= 1'b0;
    end
    if (cmd.cmp_init) begin
      lmis    <= len_ne;
      shorter <= len_min;
      dsum    <= (len_ne && accept) ? len_diff : '0;
      pos     <= '0;
    end
    if (cmd.cmp_acc) begin
      dsum <= dsum + LW'(st_q != cb_q);
      pos  <= pos + LW'(1);
    end
    if (cmd.cmp_end) begin
      near_vec[s_idx] <= near_now;
      if (!lmis && (dsum == '0)) begin
        found <= 1'b1;
        fidx  <= s_idx;
      end
      s    <= s + DW'(1);
      base <= base + BW'(MAX_LENGTH);
    end
    if (cmd.new_start) begin
      nidx <= d_idx;
      pos  <= '0;
    end
    if (cmd.copy_wr) pos <= pos + LW'(1);
    if (cmd.new_done || cmd.read_done) s <= '0;
    if (cmd.s_inc) s <= s + DW'(1);
    if (cmd.join_ra) ra <= par_q;
    if (cmd.join_rb) begin
      lo <= (ra < par_q) ? ra : par_q;
      hi <= (ra < par_q) ? par_q : ra;
      k  <= '0;
    end
    if (cmd.rel_wr) k <= k + DW'(1);
    if (cmd.best_a) begin
      root  <= par_q;
      cov_s <= cov_q;
    end
  end

  // Sequence store and current read buffer.
  always_ff @(posedge clk) begin
    if (take && (cur_len < LW'(MAX_LENGTH))) cbuf_mem[cur_len[LIW-1:0]] <= s_axis_tdata;
    if (cmd.copy_wr) store_mem[st_addr] <= cb_q;
    cb_q <= cbuf_mem[pos[LIW-1:0]];
    st_q <= store_mem[st_addr];
  end

  // Per-sequence tables.
  always_ff @(posedge clk) begin
    if (cmd.new_start) begin
      len_mem[d_idx]   <= cur_len;
      first_mem[d_idx] <= rc_idx;
    end
    if (cmd.new_start) cov_mem[d_idx] <= RW'(1);
    else if (cmd.cov_inc) cov_mem[fidx] <= cov_q + RW'(1);
    if (cmd.new_start) par_mem[d_idx] <= d_idx;
    else if (cmd.rel_wr && (par_q == hi)) par_mem[k_idx] <= lo;
    if (cmd.best_a && (par_q == s_idx)) best_mem[s_idx] <= s_idx;
    else if (cmd.best_c && (cov_s > cov_q)) best_mem[root] <= s_idx;
    if (cmd.new_start) map_mem[rc_idx] <= d_idx;
    else if (cmd.cov_inc) map_mem[rc_idx] <= fidx;
    len_q   <= len_mem[s_idx];
    cov_q   <= cov_mem[cov_raddr];
    first_q <= first_mem[best_q];
    par_q   <= par_mem[par_raddr];
    best_q  <= best_mem[par_q];
    map_q   <= map_mem[r_idx];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_idx   <= IDX_W'(r_idx);
      o_label <= IDX_W'(first_q);
      o_ovf   <= ovf;
      o_last  <= ((r + RW'(1)) == rcount);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2 * IDX_W){1'b0}}, o_label, o_idx};
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_ovf;

  // Checks on the datapath.
  `HTC_ASSERT_ALWAYS(a_len_bound, cur_len <= LW'(MAX_LENGTH))
  `HTC_ASSERT_IMP(a_no_take_while_out, take, !out_valid)
  `HTC_ASSERT_ALWAYS(a_distinct_le_reads, int'(dcount) <= int'(rcount))
  `HTC_ASSERT_IMP(a_out_has_reads, out_valid, rcount != '0)

endmodule

`default_nettype wire
